[rtl/signed_int_to_decimal_ascii_defines.svh]
// Assertion macros for the checker file of the decimal text block.
// Depends on nothing; include once through the guard below.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SIDA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define SIDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sida_pkg.sv]
// Package for the decimal text block: widths, ASCII constants and the
// digit-extraction step shared by the pipeline stages. Depends on nothing.
package sida_pkg;
  localparam int unsigned NumDigits = 10;
  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] MinusCode = 8'd45;

  // One BCD step: add 3 to every digit of five or more, then double the
  // BCD number and shift in one binary bit.
  function automatic logic [4*NumDigits-1:0] dd_step(logic [4*NumDigits-1:0] b, logic bit_in);
    logic [4*NumDigits-1:0] t;
    t = b;
    for (int i = 0; i < NumDigits; i++) begin
      if (t[4*i+:4] >= 4'd5) t[4*i+:4] = t[4*i+:4] + 4'd3;
    end
    return {t[4*NumDigits-2:0], bit_in};
  endfunction
endpackage

[rtl/sida_dd_stage.sv]
// One pipeline stage of the double-dabble converter: eight bit steps.
// Depends on sida_pkg.
module sida_dd_stage #(
  parameter int unsigned Steps = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic        neg_i,
  input  logic [31:0] bits_i,
  input  logic [39:0] bcd_i,
  output logic        valid_o,
  output logic        neg_o,
  output logic [31:0] bits_o,
  output logic [39:0] bcd_o
);
  import sida_pkg::*;
  logic [39:0] bcd_d, bcd_q;
  logic [31:0] bits_q;
  logic        neg_q, valid_q;

  always_comb begin
    bcd_d = bcd_i;
    for (int s = 0; s < Steps; s++) begin
      bcd_d = dd_step(bcd_d, bits_i[31-s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bcd_q  <= bcd_d;
      bits_q <= bits_i << Steps;
      neg_q  <= neg_i;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bits_o  = bits_q;
  assign bcd_o   = bcd_q;
endmodule

[rtl/sida_serializer.sv]
// Output serializer: turns one BCD word into a run of ASCII characters.
// Depends on sida_pkg.
module sida_serializer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        neg_i,
  input  logic [39:0] bcd_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  char_code_o,
  output logic        last_char_o
);
  import sida_pkg::*;
  logic        busy_q, busy_d;
  logic        sign_q, sign_d;
  logic [39:0] bcd_q, bcd_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  top;

  // Index of the most significant nonzero digit, zero when all are zero.
  always_comb begin
    top = 4'd0;
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd_i[4*i+:4] != 4'd0) top = 4'(i);
    end
  end

  assign ready_o     = !busy_q || (ready_i && !sign_q && idx_q == 4'd0);
  assign valid_o     = busy_q;
  assign char_code_o = sign_q ? MinusCode : (DigitBase + {4'd0, bcd_q[4*idx_q+:4]});
  assign last_char_o = !sign_q && idx_q == 4'd0;

  always_comb begin
    busy_d = busy_q;
    sign_d = sign_q;
    bcd_d  = bcd_q;
    idx_d  = idx_q;
    if (busy_q && ready_i) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q != 4'd0) begin
        idx_d = idx_q - 4'd1;
      end else begin
        busy_d = 1'b0;
      end
    end
    if (valid_i && ready_o) begin
      busy_d = 1'b1;
      sign_d = neg_i;
      bcd_d  = bcd_i;
      idx_d  = top;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      sign_q <= sign_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end
endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, top level.
// Depends on sida_pkg, sida_dd_stage and sida_serializer.
//
// Each accepted word is a signed 32-bit value; the block returns its decimal
// text one character per output word, most significant first, with '-' ahead
// of negative values and last_char_o set on the final character. A number
// is one to eleven characters, all through the single serializer port; the
// magnitude goes through a four-stage double-dabble pipeline (eight bits per
// stage) that takes a new word every cycle unless held, and holds in place
// while its last word waits on the serializer, so none is dropped or repeated.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] value_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  char_code_o,
  output logic        last_char_o
);
  import sida_pkg::*;
  localparam int unsigned NStages = 4;

  logic        v  [NStages+1];
  logic        n  [NStages+1];
  logic [31:0] b  [NStages+1];
  logic [39:0] d  [NStages+1];
  logic        ser_ready, en;

  // The whole pipeline advances together when its tail is free or empty.
  assign en      = ser_ready || !v[NStages];
  assign ready_o = en;

  // Magnitude in 32-bit unsigned arithmetic covers the most negative value.
  assign v[0] = valid_i;
  assign n[0] = value_i[31];
  assign b[0] = value_i[31] ? (32'd0 - value_i) : value_i;
  assign d[0] = '0;

  for (genvar g = 0; g < NStages; g++) begin : g_stage
    sida_dd_stage #(.Steps(8)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v[g]), .neg_i(n[g]), .bits_i(b[g]), .bcd_i(d[g]),
      .valid_o(v[g+1]), .neg_o(n[g+1]), .bits_o(b[g+1]), .bcd_o(d[g+1])
    );
  end

  sida_serializer u_ser (
    .clk_i, .rst_ni,
    .valid_i(v[NStages]), .ready_o(ser_ready),
    .neg_i(n[NStages]), .bcd_i(d[NStages]),
    .valid_o, .ready_i, .char_code_o, .last_char_o
  );
endmodule

[rtl/sida_checker.sv]
// Port-level checker for the decimal text block, bound to the top level.
// Depends on sida_pkg and signed_int_to_decimal_ascii_defines.svh.
`include "signed_int_to_decimal_ascii_defines.svh"
module sida_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       ready_i,
  input logic [7:0] char_code_o,
  input logic       last_char_o
);
  import sida_pkg::*;
  logic is_digit;
  logic is_minus;

  assign is_digit = (char_code_o >= DigitBase) && (char_code_o <= DigitBase + 8'd9);
  assign is_minus = (char_code_o == MinusCode);

  `SIDA_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, valid_o && !ready_i, valid_o)
  `SIDA_ASSERT(a_code_range, clk_i, rst_ni, valid_o |-> (is_minus || is_digit))
  `SIDA_ASSERT(a_minus_not_last, clk_i, rst_ni, valid_o && is_minus |-> !last_char_o)
  `SIDA_ASSERT_NEXT(a_minus_first, clk_i, rst_ni, valid_o && ready_i && is_minus, valid_o && !is_minus)
endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk_i, .rst_ni, .valid_o, .ready_i, .char_code_o, .last_char_o
);

[bench/tb_signed_int_to_decimal_ascii.sv]
// Testbench for the signed integer to decimal text block: drives 32-bit words,
// predicts the character run of each and checks every output word in order.
// Depends on the RTL top level signed_int_to_decimal_ascii only.
module tb_signed_int_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [31:0] value_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [7:0]  char_code_o;
  logic        last_char_o;

  // Characters still owed by the block, oldest first.
  text_char_t  pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned chars_seen = 0;
  int unsigned idle_cycles = 0;
  // Percentages of cycles in which each side idles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // While set, the receiver drops ready regardless of its idle setting.
  bit          recv_hold = 1'b0;

  signed_int_to_decimal_ascii u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .ready_o    (ready_o),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .ready_i    (ready_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Appends the decimal text of one value: sign first, then the magnitude's
  // digits with no leading zeros, the last one flagged.
  task automatic push_decimal_text(input logic [31:0] val);
    logic [31:0] mag;
    logic [3:0]  digits[10];
    int          num_digits;
    text_char_t  ch;
    num_digits = 0;
    mag = val[31] ? (32'd0 - val) : val;
    do begin
      digits[num_digits] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      num_digits++;
    end while (mag != 0);
    if (val[31]) begin
      ch.code = CharMinus;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      ch.code = CharZero + 8'(digits[k]);
      ch.last = (k == 0);
      pending_chars.push_back(ch);
    end
  endtask

  // Offers one word, with a random gap first, and waits for acceptance.
  // The expectation is filed at the accepting edge, before any of its
  // characters can come out. Valid drops only in a gap or when draining.
  task automatic send_word(input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    value_i <= val;
    do @(posedge clk_i); while (!ready_o);
    push_decimal_text(val);
    words_sent++;
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Values whose digit count is chosen first, so every length from one to
  // ten digits turns up often, with either sign.
  function automatic logic [31:0] random_value();
    logic [31:0] mag;
    int unsigned ndig;
    ndig = $urandom_range(10, 1);
    case ($urandom_range(9))
      0: return $urandom();
      1: return {1'($urandom_range(1)), 30'd0, 1'($urandom_range(1))};
      default: begin
        mag = 0;
        for (int i = 0; i < ndig; i++) mag = mag * 10 + $urandom_range(9);
        if (ndig == 10 && mag > 32'd2147483647) mag = mag - 32'd2000000000;
        return $urandom_range(1) ? (32'd0 - mag) : mag;
      end
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] dir_vals[$];
    dir_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                 32'd99, 32'd100, 32'd999_999_999, 32'd1_000_000_000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'hFFFF_FFF7, 32'd4_294_967_286,
                 32'd123_456_789, 32'hF0F0_F0F0, 32'h0F0F_0F0F};
    foreach (dir_vals[i]) send_word(dir_vals[i]);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned s_pct,
                             input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_word(random_value());
    wait_drained();
  endtask

  // The receiver stops for a long stretch while words keep coming, so the
  // pipeline fills and the block must back-pressure its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (30) send_word(random_value());
    join
    wait_drained();
  endtask

  // The receiver idles at random and drives ready only at rising edges.
  always @(posedge clk_i) begin
    if (rst_ni) ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Checks each accepted character against the oldest expectation.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && valid_o && ready_i) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected character %0d last %0b", char_code_o, last_char_o);
      end else begin
        want = pending_chars.pop_front();
        if (char_code_o !== want.code || last_char_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("char mismatch: expected %0d/%0b, got %0d/%0b",
                     want.code, want.last, char_code_o, last_char_o);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random(105, 38, 77);
    test_random(105, 77, 38);
    test_backpressure();
    test_random(110, 0, 0);
    repeat (50) @(posedge clk_i);
    if (pending_chars.size() != 0) mismatch_count += pending_chars.size();
    $display("Converted %0d words to %0d characters, covering every length",
             words_sent, chars_seen);
    $display("and sign, the extremes, idle mixes and a long output stall.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
